// ===== src/nrrd_pkg.sv =====
`default_nettype none

package nrrd_pkg;

	// item kinds on the input channel
	typedef enum logic {
		OP_POLL   = 1'b0,
		OP_STATUS = 1'b1
	} opcode_t;

	// result kinds
	typedef enum logic [1:0] {
		ACT_EMPTY   = 2'd0,
		ACT_DELIVER = 2'd1,
		ACT_CORRUPT = 2'd2,
		ACT_STATUS  = 2'd3
	} action_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_START  = 2'd1,
		REG_STOP   = 2'd2
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned PAGE_W      = 8;
	localparam int unsigned ADDR_W      = 16;
	localparam int unsigned LEN_W       = 11;
	localparam int unsigned HLEN_W      = 16;
	localparam int unsigned CNT_W       = 32;

	localparam logic [PAGE_W-1:0] START_PAGE_RST = 8'd70;
	localparam logic [PAGE_W-1:0] STOP_PAGE_RST  = 8'd128;

	localparam logic [LEN_W-1:0]  MAX_PAYLOAD  = 11'd1518;
	localparam logic [HLEN_W-1:0] HDR_BYTES    = 16'd4;
	localparam logic [HLEN_W-1:0] HDR_LEN_MAX  = 16'd1522;
	localparam logic [7:0]        HDR_OFFSET   = 8'h04;

	// interrupt status bit positions
	localparam int unsigned ISR_RX_OK  = 0;
	localparam int unsigned ISR_RX_ERR = 2;
	localparam int unsigned ISR_TX_ERR = 3;
	localparam int unsigned ISR_OVF    = 4;

endpackage

`default_nettype wire

// ===== src/nic_rx_ring_drain_unit.sv =====
// an accepted item passes through the input register, then the result register
// one item per cycle unless stalled; the result register frees the input side when it is taken
// the input is stalled only while the input register is full and the result register is held
// reset (arst_n low, asynchronous): both stages empty, read page = 71, counters zero,
// enable 0, ring start page 70, ring stop page 128
`default_nettype none

module nic_rx_ring_drain_unit import nrrd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,

	// input channel
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   opcode,
	input  wire logic [PAGE_W-1:0]      write_page,
	input  wire logic [7:0]             hdr_status,
	input  wire logic [PAGE_W-1:0]      hdr_next_page,
	input  wire logic [HLEN_W-1:0]      hdr_length,
	input  wire logic [7:0]             isr_bits,

	// result channel
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [1:0]                  action,
	output logic                        ring_reset,
	output logic                        drain_needed,
	output logic [ADDR_W-1:0]           first_addr,
	output logic [LEN_W-1:0]            first_len,
	output logic [LEN_W-1:0]            second_len,
	output logic [LEN_W-1:0]            data_len,
	output logic [PAGE_W-1:0]           boundary_page,
	output logic [ADDR_W-1:0]           next_header_addr,
	output logic [CNT_W-1:0]            rx_error_count,
	output logic [CNT_W-1:0]            tx_error_count,
	output logic [CNT_W-1:0]            rx_dropped_count
);

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic              enable_q;
	logic [PAGE_W-1:0] start_page_q;
	logic [PAGE_W-1:0] stop_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			start_page_q <= START_PAGE_RST;
			stop_page_q  <= STOP_PAGE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ENABLE: enable_q     <= cfg_data[0];
				REG_START:  start_page_q <= cfg_data;
				REG_STOP:   stop_page_q  <= cfg_data;
				default: ; // unmapped index, write is dropped
			endcase
		end
	end

	// ---------------------------------------------------------------
	// handshake: stage 1 moves into the result register when that
	// register is empty or its transfer completes this cycle
	// ---------------------------------------------------------------
	logic s1_valid_q;
	logic out_valid_q;
	logic out_free;
	logic advance;
	logic in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// input register
	// ---------------------------------------------------------------
	opcode_t           opcode_s1;
	logic [PAGE_W-1:0] write_page_s1;
	logic [7:0]        hdr_status_s1;
	logic [PAGE_W-1:0] hdr_next_page_s1;
	logic [HLEN_W-1:0] hdr_length_s1;
	logic [7:0]        isr_bits_s1;

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1        <= opcode_t'(opcode);
			write_page_s1    <= write_page;
			hdr_status_s1    <= hdr_status;
			hdr_next_page_s1 <= hdr_next_page;
			hdr_length_s1    <= hdr_length;
			isr_bits_s1      <= isr_bits;
		end
	end

	// ---------------------------------------------------------------
	// ring state; only changes when a result is loaded, so while a
	// result waits these registers still hold its after-item values
	// ---------------------------------------------------------------
	logic [PAGE_W-1:0] read_page_q;
	logic [CNT_W-1:0]  rx_errors_q;
	logic [CNT_W-1:0]  tx_errors_q;
	logic [CNT_W-1:0]  rx_dropped_q;

	// ---------------------------------------------------------------
	// per-item evaluation
	// ---------------------------------------------------------------
	action_t           act_c;
	logic              rreset_c;
	logic              drain_c;
	logic [ADDR_W-1:0] faddr_c;
	logic [LEN_W-1:0]  flen_c;
	logic [LEN_W-1:0]  slen_c;
	logic [LEN_W-1:0]  plen_c;
	logic [PAGE_W-1:0] bnd_c;
	logic              take_next_c;   // read page follows header's next page
	logic              restart_c;     // read page back to start + 1
	logic              rx_inc_c;
	logic              tx_inc_c;
	logic              drop_inc_c;

	logic              hdr_ok;
	logic [HLEN_W-1:0] plen_raw;
	logic [LEN_W-1:0]  plen_clamped;
	logic [ADDR_W-1:0] pkt_addr;
	logic [ADDR_W-1:0] ring_end;
	logic [ADDR_W:0]   seg_end;       // one bit wider to catch carry past 64k
	logic [ADDR_W-1:0] to_end;

	assign hdr_ok = hdr_status_s1[0]
		&& (hdr_next_page_s1 >= start_page_q)
		&& (hdr_next_page_s1 < stop_page_q)
		&& (hdr_length_s1 >= HDR_BYTES)
		&& (hdr_length_s1 <= HDR_LEN_MAX);

	assign plen_raw     = hdr_length_s1 - HDR_BYTES;
	assign plen_clamped = (plen_raw > HLEN_W'(MAX_PAYLOAD)) ? MAX_PAYLOAD
	                                                        : plen_raw[LEN_W-1:0];
	// payload starts past the 4-byte header at the read page
	assign pkt_addr = {read_page_q, HDR_OFFSET};
	assign ring_end = {stop_page_q, 8'h00};
	assign seg_end  = {1'b0, pkt_addr} + (ADDR_W+1)'(plen_clamped);
	assign to_end   = ring_end - pkt_addr;

	always_comb begin
		act_c       = ACT_EMPTY;
		rreset_c    = 1'b0;
		drain_c     = 1'b0;
		faddr_c     = '0;
		flen_c      = '0;
		slen_c      = '0;
		plen_c      = '0;
		bnd_c       = '0;
		take_next_c = 1'b0;
		restart_c   = 1'b0;
		rx_inc_c    = 1'b0;
		tx_inc_c    = 1'b0;
		drop_inc_c  = 1'b0;

		if (opcode_s1 == OP_POLL) begin
			if (write_page_s1 == read_page_q) begin
				act_c = ACT_EMPTY;
			end else if (!hdr_ok) begin
				// corrupt header: count it and restart the ring
				act_c     = ACT_CORRUPT;
				rreset_c  = 1'b1;
				rx_inc_c  = 1'b1;
				bnd_c     = start_page_q;
				restart_c = 1'b1;
			end else begin
				act_c       = ACT_DELIVER;
				plen_c      = plen_clamped;
				faddr_c     = pkt_addr;
				take_next_c = 1'b1;
				if (seg_end <= {1'b0, ring_end}) begin
					// fits before the ring end
					flen_c = plen_clamped;
				end else if (pkt_addr < ring_end) begin
					// wraps: tail of the ring, then the rest from the start
					flen_c = to_end[LEN_W-1:0];
					slen_c = plen_clamped - to_end[LEN_W-1:0];
				end else begin
					// read page lies outside the ring, all from the start
					slen_c = plen_clamped;
				end
				// boundary trails the next packet by one page, wrapping at ring start
				bnd_c = (hdr_next_page_s1 == start_page_q) ? (stop_page_q - 8'd1)
				                                           : (hdr_next_page_s1 - 8'd1);
			end
		end else begin
			act_c = ACT_STATUS;
			if (enable_q && (isr_bits_s1 != 8'h00)) begin
				drain_c  = isr_bits_s1[ISR_RX_OK];
				rx_inc_c = isr_bits_s1[ISR_RX_ERR];
				tx_inc_c = isr_bits_s1[ISR_TX_ERR];
				if (isr_bits_s1[ISR_OVF]) begin
					// overflow: count the drop and restart the ring
					drop_inc_c = 1'b1;
					rreset_c   = 1'b1;
					bnd_c      = start_page_q;
					restart_c  = 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// state update, in step with the result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_page_q  <= START_PAGE_RST + 8'd1;
			rx_errors_q  <= '0;
			tx_errors_q  <= '0;
			rx_dropped_q <= '0;
		end else if (advance) begin
			if (restart_c) begin
				read_page_q <= start_page_q + 8'd1;
			end else if (take_next_c) begin
				read_page_q <= hdr_next_page_s1;
			end
			if (rx_inc_c) begin
				rx_errors_q <= rx_errors_q + 32'd1;
			end
			if (tx_inc_c) begin
				tx_errors_q <= tx_errors_q + 32'd1;
			end
			if (drop_inc_c) begin
				rx_dropped_q <= rx_dropped_q + 32'd1;
			end
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	action_t           action_q;
	logic              ring_reset_q;
	logic              drain_needed_q;
	logic [ADDR_W-1:0] first_addr_q;
	logic [LEN_W-1:0]  first_len_q;
	logic [LEN_W-1:0]  second_len_q;
	logic [LEN_W-1:0]  data_len_q;
	logic [PAGE_W-1:0] boundary_page_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q        <= act_c;
			ring_reset_q    <= rreset_c;
			drain_needed_q  <= drain_c;
			first_addr_q    <= faddr_c;
			first_len_q     <= flen_c;
			second_len_q    <= slen_c;
			data_len_q      <= plen_c;
			boundary_page_q <= bnd_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = action_q;
	assign ring_reset    = ring_reset_q;
	assign drain_needed  = drain_needed_q;
	assign first_addr    = first_addr_q;
	assign first_len     = first_len_q;
	assign second_len    = second_len_q;
	assign data_len      = data_len_q;
	assign boundary_page = boundary_page_q;

	// next header address and counters come straight from the ring state
	assign next_header_addr = {read_page_q, 8'h00};
	assign rx_error_count   = rx_errors_q;
	assign tx_error_count   = tx_errors_q;
	assign rx_dropped_count = rx_dropped_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q))
		else $error("input stalled with a free pipeline");

	a_ring_reset_pages: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ring_reset) |->
			((boundary_page == start_page_q)
			&& (next_header_addr == {start_page_q + 8'd1, 8'h00})))
		else $error("ring reset result with wrong boundary or read page");

	a_segments_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (action == ACT_DELIVER)) |->
			((first_len + second_len) == data_len))
		else $error("payload segments do not add up");

	a_empty_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (action == ACT_EMPTY)) |->
			(!ring_reset && (data_len == '0) && (boundary_page == '0)))
		else $error("empty ring result carries data");

	a_counters_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			($stable(rx_error_count) && $stable(next_header_addr)))
		else $error("ring state moved under a held result");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import nrrd_pkg::*;

	// header length limits and payload clamp, as the ring format defines them
	localparam logic [HLEN_W-1:0] HDR_MIN       = 16'd4;
	localparam logic [HLEN_W-1:0] HDR_LEN_LIMIT = 16'd1522;
	localparam logic [LEN_W-1:0]  PAYLOAD_LIMIT = 11'd1518;

	// cycles with no transfer on either side before the run is called hung
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASES        = 8;
	localparam int ITEMS_A_PHASE = 150;
	localparam int LONG_HOLD     = 300;

	typedef struct {
		opcode_t           op;
		logic [PAGE_W-1:0] wpage;
		logic [7:0]        hstat;
		logic [PAGE_W-1:0] hnext;
		logic [HLEN_W-1:0] hlen;
		logic [7:0]        isr;
	} ring_item_t;

	typedef struct {
		action_t           act;
		logic              rreset;
		logic              drain;
		logic [ADDR_W-1:0] faddr;
		logic [LEN_W-1:0]  flen;
		logic [LEN_W-1:0]  slen;
		logic [LEN_W-1:0]  plen;
		logic [PAGE_W-1:0] bnd;
		logic [ADDR_W-1:0] nha;
		logic [CNT_W-1:0]  rx_err;
		logic [CNT_W-1:0]  tx_err;
		logic [CNT_W-1:0]  dropped;
	} drain_result_t;

	// one row of the directed part: either a register write or an item
	typedef struct {
		logic          is_cfg;
		cfg_reg_t      idx;
		logic [7:0]    data;
		ring_item_t    it;
		logic          pinned;
		drain_result_t want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   opcode;
	logic [PAGE_W-1:0]      write_page;
	logic [7:0]             hdr_status;
	logic [PAGE_W-1:0]      hdr_next_page;
	logic [HLEN_W-1:0]      hdr_length;
	logic [7:0]             isr_bits;
	logic                   out_valid;
	logic                   out_stall;
	logic [1:0]             action;
	logic                   ring_reset;
	logic                   drain_needed;
	logic [ADDR_W-1:0]      first_addr;
	logic [LEN_W-1:0]       first_len;
	logic [LEN_W-1:0]       second_len;
	logic [LEN_W-1:0]       data_len;
	logic [PAGE_W-1:0]      boundary_page;
	logic [ADDR_W-1:0]      next_header_addr;
	logic [CNT_W-1:0]       rx_error_count;
	logic [CNT_W-1:0]       tx_error_count;
	logic [CNT_W-1:0]       rx_dropped_count;

	nic_rx_ring_drain_unit DUT (.*);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of the block's registers and state
	logic              en_q;
	logic [PAGE_W-1:0] ring_start;
	logic [PAGE_W-1:0] ring_stop;
	logic [PAGE_W-1:0] rd_page;
	logic [CNT_W-1:0]  rx_err_q;
	logic [CNT_W-1:0]  tx_err_q;
	logic [CNT_W-1:0]  dropped_q;

	drain_result_t drain_queue[$];
	stim_row_t     stim_rows[$];
	int            mismatches = 0;
	int            quiet = 0;

	// idling knobs for the two sides; 0 means no idling
	int send_max_gap = 10;
	int recv_max_gap = 10;
	int hold_request = 0;

	// works out the result of one accepted item and moves the state along
	function automatic drain_result_t drain_step(input ring_item_t it);
		drain_result_t     r;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] ring_end;
		logic [LEN_W-1:0]  len;
		r = '{ACT_EMPTY, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0, '0};
		if (it.op == OP_POLL) begin
			if (it.wpage == rd_page) begin
				// ring empty, nothing moves
				r.act = ACT_EMPTY;
			end else if (!it.hstat[0] || it.hnext < ring_start || it.hnext >= ring_stop ||
					it.hlen < HDR_MIN || it.hlen > HDR_LEN_LIMIT) begin
				// corrupt header: count it and restart the ring
				r.act = ACT_CORRUPT;
				r.rreset = 1'b1;
				r.bnd = ring_start;
				rx_err_q = rx_err_q + 1;
				rd_page = ring_start + 8'd1;
			end else begin
				addr = {rd_page, 8'h00} + 16'd4;
				ring_end = {ring_stop, 8'h00};
				len = LEN_W'(it.hlen - HDR_MIN);
				if (len > PAYLOAD_LIMIT) begin
					len = PAYLOAD_LIMIT;
				end
				r.act = ACT_DELIVER;
				r.plen = len;
				r.faddr = addr;
				if (17'(addr) + 17'(len) <= 17'(ring_end)) begin
					r.flen = len;
				end else if (addr < ring_end) begin
					// payload runs past the ring end, rest comes from the ring start
					r.flen = LEN_W'(ring_end - addr);
					r.slen = len - r.flen;
				end else begin
					// read page outside the ring: whole payload from the ring start
					r.slen = len;
				end
				r.bnd = (it.hnext == ring_start) ? ring_stop - 8'd1 : it.hnext - 8'd1;
				rd_page = it.hnext;
			end
		end else begin
			r.act = ACT_STATUS;
			if (en_q && it.isr != 8'h00) begin
				r.drain = it.isr[ISR_RX_OK];
				if (it.isr[ISR_RX_ERR]) begin
					rx_err_q = rx_err_q + 1;
				end
				if (it.isr[ISR_TX_ERR]) begin
					tx_err_q = tx_err_q + 1;
				end
				if (it.isr[ISR_OVF]) begin
					// overflow drops the ring contents
					dropped_q = dropped_q + 1;
					r.rreset = 1'b1;
					r.bnd = ring_start;
					rd_page = ring_start + 8'd1;
				end
			end
		end
		r.nha = {rd_page, 8'h00};
		r.rx_err = rx_err_q;
		r.tx_err = tx_err_q;
		r.dropped = dropped_q;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// register write at the next rising edge; write enable is left high
	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ENABLE: en_q = val[0];
			REG_START:  ring_start = val;
			REG_STOP:   ring_stop = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// stop offering and wait until every expected result has been taken
	task automatic settle();
		in_valid <= 1'b0;
		while (drain_queue.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// offer one item after a random gap, then book its expected result on transfer
	task automatic transfer_item(input ring_item_t it, input logic pinned,
			input drain_result_t want);
		int            gap;
		drain_result_t pred;
		gap = (send_max_gap == 0) ? 0 : $urandom_range(0, send_max_gap);
		cfg_we <= 1'b0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode <= it.op;
		write_page <= it.wpage;
		hdr_status <= it.hstat;
		hdr_next_page <= it.hnext;
		hdr_length <= it.hlen;
		isr_bits <= it.isr;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		// predictor always runs so its state tracks the block
		pred = drain_step(it);
		drain_queue.push_back(pinned ? want : pred);
	endtask

	task automatic add_cfg_row(input cfg_reg_t idx, input logic [7:0] val);
		stim_row_t row;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = val;
		row.pinned = 1'b0;
		stim_rows.push_back(row);
	endtask

	task automatic add_item_row(input ring_item_t it);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.it = it;
		row.pinned = 1'b0;
		stim_rows.push_back(row);
	endtask

	task automatic add_pinned_row(input ring_item_t it, input drain_result_t want);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.it = it;
		row.pinned = 1'b1;
		row.want = want;
		stim_rows.push_back(row);
	endtask

	// result side: random stalls, a long hold-off on request, in-order compare
	initial begin : result_side
		int            pause;
		drain_result_t want;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			pause = (recv_max_gap == 0) ? 0 : $urandom_range(0, recv_max_gap);
			pause += hold_request;
			hold_request = 0;
			if (pause != 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (drain_queue.size() == 0) begin
				$error("result transfer with nothing expected: action %0d", action);
				mismatches++;
			end else begin
				want = drain_queue.pop_front();
				check_field("action", want.act, action);
				check_field("ring_reset", want.rreset, ring_reset);
				check_field("drain_needed", want.drain, drain_needed);
				check_field("first_addr", want.faddr, first_addr);
				check_field("first_len", want.flen, first_len);
				check_field("second_len", want.slen, second_len);
				check_field("data_len", want.plen, data_len);
				check_field("boundary_page", want.bnd, boundary_page);
				check_field("next_header_addr", want.nha, next_header_addr);
				check_field("rx_error_count", want.rx_err, rx_error_count);
				check_field("tx_error_count", want.tx_err, tx_error_count);
				check_field("rx_dropped_count", want.dropped, rx_dropped_count);
			end
		end
	end

	// watchdog: too long without any transfer means the block is hung
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		ring_item_t        it;
		stim_row_t         row;
		drain_result_t     none;
		int                pick;
		logic              en_pick;
		logic [PAGE_W-1:0] s_pg;
		logic [PAGE_W-1:0] e_pg;

		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = 1'b0;
		write_page = '0;
		hdr_status = '0;
		hdr_next_page = '0;
		hdr_length = '0;
		isr_bits = '0;
		none = '{ACT_EMPTY, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0, '0};

		// predictor reset state
		en_q = 1'b0;
		ring_start = 8'd70;
		ring_stop = 8'd128;
		rd_page = 8'd71;
		rx_err_q = '0;
		tx_err_q = '0;
		dropped_q = '0;

		// directed rows; read page starts at 71, so the next header sits at 0x4700
		// empty ring right after reset
		add_pinned_row('{OP_POLL, 8'd71, 8'h00, 8'd0, 16'd0, 8'h00},
			'{ACT_EMPTY, 1'b0, 1'b0, 16'd0, 11'd0, 11'd0, 11'd0, 8'd0, 16'h4700,
			32'd0, 32'd0, 32'd0});
		// status while disabled: nothing counted
		add_pinned_row('{OP_STATUS, 8'd0, 8'h00, 8'd0, 16'd0, 8'hFF},
			'{ACT_STATUS, 1'b0, 1'b0, 16'd0, 11'd0, 11'd0, 11'd0, 8'd0, 16'h4700,
			32'd0, 32'd0, 32'd0});
		// corrupt headers: status bit clear, next at stop, next below start,
		// length too short, length one past the limit, length at its maximum
		add_pinned_row('{OP_POLL, 8'd0, 8'h00, 8'd100, 16'd100, 8'h00},
			'{ACT_CORRUPT, 1'b1, 1'b0, 16'd0, 11'd0, 11'd0, 11'd0, 8'd70, 16'h4700,
			32'd1, 32'd0, 32'd0});
		add_pinned_row('{OP_POLL, 8'd0, 8'h01, 8'd128, 16'd100, 8'h00},
			'{ACT_CORRUPT, 1'b1, 1'b0, 16'd0, 11'd0, 11'd0, 11'd0, 8'd70, 16'h4700,
			32'd2, 32'd0, 32'd0});
		add_pinned_row('{OP_POLL, 8'd0, 8'hFF, 8'd69, 16'd100, 8'h00},
			'{ACT_CORRUPT, 1'b1, 1'b0, 16'd0, 11'd0, 11'd0, 11'd0, 8'd70, 16'h4700,
			32'd3, 32'd0, 32'd0});
		add_pinned_row('{OP_POLL, 8'd0, 8'h01, 8'd100, 16'd3, 8'h00},
			'{ACT_CORRUPT, 1'b1, 1'b0, 16'd0, 11'd0, 11'd0, 11'd0, 8'd70, 16'h4700,
			32'd4, 32'd0, 32'd0});
		add_pinned_row('{OP_POLL, 8'd0, 8'h01, 8'd100, 16'd1523, 8'h00},
			'{ACT_CORRUPT, 1'b1, 1'b0, 16'd0, 11'd0, 11'd0, 11'd0, 8'd70, 16'h4700,
			32'd5, 32'd0, 32'd0});
		add_pinned_row('{OP_POLL, 8'd0, 8'h01, 8'd100, 16'hFFFF, 8'h00},
			'{ACT_CORRUPT, 1'b1, 1'b0, 16'd0, 11'd0, 11'd0, 11'd0, 8'd70, 16'h4700,
			32'd6, 32'd0, 32'd0});
		// zero payload with next at ring start (boundary wraps to stop - 1)
		add_item_row('{OP_POLL, 8'd0, 8'h01, 8'd70, 16'd4, 8'h00});
		// largest packet, then a split at the ring end from the last page
		add_item_row('{OP_POLL, 8'd0, 8'hFF, 8'd127, 16'd1522, 8'h00});
		add_item_row('{OP_POLL, 8'd0, 8'h01, 8'd71, 16'd1000, 8'h00});
		add_item_row('{OP_POLL, 8'd71, 8'h01, 8'd90, 16'd500, 8'h00});
		// enabled status: zero, each single event, overflow, all bits
		add_cfg_row(REG_ENABLE, 8'd1);
		add_item_row('{OP_STATUS, 8'd0, 8'h00, 8'd0, 16'd0, 8'h00});
		add_item_row('{OP_STATUS, 8'd0, 8'h00, 8'd0, 16'd0, 8'h01});
		add_item_row('{OP_STATUS, 8'd0, 8'h00, 8'd0, 16'd0, 8'h04});
		add_item_row('{OP_STATUS, 8'd0, 8'h00, 8'd0, 16'd0, 8'h08});
		add_item_row('{OP_STATUS, 8'd0, 8'h00, 8'd0, 16'd0, 8'h10});
		add_item_row('{OP_STATUS, 8'd0, 8'h00, 8'd0, 16'd0, 8'hFF});
		add_item_row('{OP_POLL, 8'd255, 8'h01, 8'd100, 16'd600, 8'h00});
		// shrink the ring under the read page: whole payload from ring start
		add_cfg_row(REG_START, 8'd0);
		add_cfg_row(REG_STOP, 8'd50);
		add_item_row('{OP_POLL, 8'd0, 8'h01, 8'd10, 16'd200, 8'h00});
		add_item_row('{OP_POLL, 8'd0, 8'h01, 8'd0, 16'd64, 8'h00});
		// start equal to stop at the top page: every header corrupt, page wraps to 0
		add_cfg_row(REG_START, 8'd255);
		add_cfg_row(REG_STOP, 8'd255);
		add_item_row('{OP_POLL, 8'd7, 8'h01, 8'd255, 16'd100, 8'h00});
		// widest ring, split near the top of the address space
		add_cfg_row(REG_START, 8'd0);
		add_item_row('{OP_POLL, 8'd1, 8'h01, 8'd254, 16'd1522, 8'h00});
		add_item_row('{OP_POLL, 8'd1, 8'h01, 8'd0, 16'd1522, 8'h00});
		// single page ring
		add_cfg_row(REG_STOP, 8'd1);
		add_item_row('{OP_POLL, 8'd5, 8'h01, 8'd0, 16'd304, 8'h00});
		add_cfg_row(REG_ENABLE, 8'd0);
		add_item_row('{OP_STATUS, 8'd0, 8'h00, 8'd0, 16'd0, 8'h10});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk
		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.is_cfg) begin
				settle();
				write_reg(row.idx, row.data);
			end else begin
				transfer_item(row.it, row.pinned, row.want);
			end
		end

		// random phases, each with its own ring setup and idling pattern
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					en_pick = 1'b1;
					s_pg = 8'd0;
					e_pg = 8'd255;
				end
				1: begin
					en_pick = 1'b1;
					s_pg = 8'd254;
					e_pg = 8'd255;
				end
				2: begin
					// start past stop
					en_pick = 1'b1;
					s_pg = 8'd200;
					e_pg = 8'd10;
				end
				default: begin
					en_pick = ($urandom_range(0, 3) != 0);
					s_pg = 8'($urandom_range(0, 250));
					e_pg = 8'($urandom_range(s_pg + 1, 255));
					if ($urandom_range(0, 4) == 0) begin
						e_pg = 8'($urandom_range(1, 255));
					end
				end
			endcase
			write_reg(REG_ENABLE, {7'd0, en_pick});
			write_reg(REG_START, s_pg);
			write_reg(REG_STOP, e_pg);

			// idling pattern: both, none, sender only, receiver only
			send_max_gap = (ph % 4 == 1 || ph % 4 == 3) ? 0 : 10;
			recv_max_gap = (ph % 4 == 1 || ph % 4 == 2) ? 0 : 10;
			// long receiver hold-off so the block fills and stalls its input
			if (ph == 5) begin
				hold_request = LONG_HOLD;
			end

			for (int n = 0; n < ITEMS_A_PHASE; n++) begin
				it.op = OP_POLL;
				it.wpage = 8'($urandom);
				it.hstat = 8'($urandom);
				it.hnext = 8'($urandom);
				it.hlen = 16'($urandom);
				it.isr = 8'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					// well-formed header with random content; next page forced into the ring only when start is below stop
					it.hstat[0] = 1'b1;
					if (ring_start < ring_stop) begin
						case ($urandom_range(0, 9))
							0: it.hnext = ring_start;
							1: it.hnext = ring_stop - 8'd1;
							default: it.hnext = 8'($urandom_range(ring_start, ring_stop - 1));
						endcase
					end
					case ($urandom_range(0, 9))
						0: it.hlen = HDR_MIN;
						1: it.hlen = HDR_MIN + 16'd1;
						2: it.hlen = HDR_LEN_LIMIT;
						3: it.hlen = HDR_LEN_LIMIT - 16'd1;
						4, 5, 6: it.hlen = 16'($urandom_range(4, 100));
						default: it.hlen = 16'($urandom_range(4, 1522));
					endcase
					if (it.wpage == rd_page) begin
						it.wpage = rd_page + 8'd1;
					end
				end else if (pick < 65) begin
					it.wpage = rd_page;
				end else if (pick >= 78) begin
					it.op = OP_STATUS;
					case ($urandom_range(0, 5))
						0: it.isr = 8'h00;
						1, 2, 3: it.isr = 8'(1 << $urandom_range(0, 7));
						default: ;
					endcase
				end
				// otherwise a poll with fully random fields
				transfer_item(it, 1'b0, none);
			end
		end

		// drain everything, then leave time for any stray extra result
		settle();
		repeat (6) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
